FILE: rtl/recursive_ticket_lock_defines.svh
// Assertion macros for the recursive ticket lock.
// Depends on nothing; the asserting module must have clk and rst in scope.
`ifndef RECURSIVE_TICKET_LOCK_DEFINES_SVH
`define RECURSIVE_TICKET_LOCK_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RTLOCK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RTLOCK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rtlock_pkg.sv
// Shared constants and types for the recursive ticket lock.
// No dependencies.
package rtlock_pkg;

  localparam int CMD_W    = 3;
  localparam int CPU_W    = 6;
  localparam int CNT_W    = 16;
  localparam int TICKET_W = 32;
  localparam int RET_W    = 17;

  localparam logic [CMD_W-1:0] CMD_LOCK            = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UNLOCK          = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE_ALL     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE_BUT_ONE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ACQUIRE_COUNT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_HELD_QUERY      = 3'd5;

  localparam logic [TICKET_W-1:0] SERVING_RESET = 32'd1;

  // What one command does to the shared state.
  typedef struct packed {
    logic write;    // write the CPU's entry back
    logic draw;     // ticket dispenser advances
    logic advance;  // now-serving advances
    logic err;      // unlock at depth zero, overflow or bad CPU index
  } status_t;

endpackage

FILE: rtl/rtlock_channels.sv
// Valid/ready channel interfaces for the recursive ticket lock.
// Depends on rtlock_pkg.
interface rtlock_req_if import rtlock_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [CPU_W-1:0] cpu_id;
  logic [CNT_W-1:0] lock_count;

  modport source (output valid, command, cpu_id, lock_count, input ready);
  modport sink (input valid, command, cpu_id, lock_count, output ready);
endinterface

interface rtlock_rsp_if import rtlock_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TICKET_W-1:0]     owned_ticket;
  logic                    granted;
  logic signed [RET_W-1:0] returned_depth;
  logic                    error;

  modport source (output valid, owned_ticket, granted, returned_depth, error,
                  input ready);
  modport sink (input valid, owned_ticket, granted, returned_depth, error,
                output ready);
endinterface

FILE: rtl/rtlock_table.sv
// Per-CPU ticket and depth store: memories with registered read, fill bits
// cleared by reset, and a bypass for a write landing on the read edge.
// Depends on rtlock_pkg.
module rtlock_table import rtlock_pkg::*; #(
  parameter int NUM_CPUS   = 64,
  parameter int DEPTH_BITS = 16,
  parameter int IDX_W      = $clog2(NUM_CPUS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_idx,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [TICKET_W-1:0]   wr_ticket,
  input  logic [DEPTH_BITS-1:0] wr_depth,
  output logic [TICKET_W-1:0]   rd_ticket,
  output logic [DEPTH_BITS-1:0] rd_depth
);

  logic [TICKET_W-1:0]   ticket_mem [NUM_CPUS];
  logic [DEPTH_BITS-1:0] depth_mem  [NUM_CPUS];
  logic [NUM_CPUS-1:0]   filled;

  logic [TICKET_W-1:0]   mem_ticket;
  logic [DEPTH_BITS-1:0] mem_depth;
  logic [TICKET_W-1:0]   last_ticket;
  logic [DEPTH_BITS-1:0] last_depth;
  logic                  entry_filled;
  logic                  bypass;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ticket_mem[wr_idx] <= wr_ticket;
      depth_mem[wr_idx]  <= wr_depth;
      last_ticket        <= wr_ticket;
      last_depth         <= wr_depth;
    end
    if (rd_en) begin
      mem_ticket <= ticket_mem[rd_idx];
      mem_depth  <= depth_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled       <= '0;
      entry_filled <= 1'b0;
      bypass       <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        entry_filled <= filled[rd_idx];
        bypass       <= wr_en && (wr_idx == rd_idx);
      end
    end
  end

  // Take the value just written when it hit the same entry on the read edge.
  always_comb begin
    if (bypass) begin
      rd_ticket = last_ticket;
      rd_depth  = last_depth;
    end else if (entry_filled) begin
      rd_ticket = mem_ticket;
      rd_depth  = mem_depth;
    end else begin
      rd_ticket = '0;
      rd_depth  = '0;
    end
  end

endmodule

FILE: rtl/rtlock_update.sv
// Command logic: new ticket and depth of one CPU, counter updates, result.
// Depends on rtlock_pkg.
module rtlock_update import rtlock_pkg::*; #(
  parameter int DEPTH_BITS = 16
) (
  input  logic [CMD_W-1:0]        command,
  input  logic [CNT_W-1:0]        lock_count,
  input  logic                    in_range,
  input  logic [TICKET_W-1:0]     cur_ticket,
  input  logic [DEPTH_BITS-1:0]   cur_depth,
  input  logic [TICKET_W-1:0]     next_ticket,
  input  logic [TICKET_W-1:0]     now_serving,
  output logic [TICKET_W-1:0]     new_ticket,
  output logic [DEPTH_BITS-1:0]   new_depth,
  output logic [TICKET_W-1:0]     next_ticket_next,
  output logic [TICKET_W-1:0]     now_serving_next,
  output status_t                 status,
  output logic [TICKET_W-1:0]     owned_ticket,
  output logic                    granted,
  output logic signed [RET_W-1:0] returned_depth
);

  localparam int SUM_W = ((DEPTH_BITS > CNT_W) ? DEPTH_BITS : CNT_W) + 1;
  localparam int WIDE_W = (DEPTH_BITS > RET_W) ? DEPTH_BITS : RET_W;

  logic [SUM_W-1:0]      add_n;
  logic [SUM_W-1:0]      sum;
  logic                  overflow;
  logic                  depth_zero;
  logic                  take;
  logic [WIDE_W-1:0]     depth_wide;
  logic [WIDE_W-1:0]     depth_less;
  logic [RET_W-1:0]      ret;
  logic                  draw;
  logic                  advance;
  logic                  err;

  assign add_n      = (command == CMD_LOCK) ? SUM_W'(1) : SUM_W'(lock_count);
  assign sum        = SUM_W'(cur_depth) + add_n;
  assign overflow   = |sum[SUM_W-1:DEPTH_BITS];
  assign depth_zero = (cur_depth == '0);
  assign take       = (command == CMD_LOCK) || (lock_count != '0);
  assign depth_wide = WIDE_W'(cur_depth);
  assign depth_less = depth_wide - WIDE_W'(1);

  always_comb begin
    new_ticket = cur_ticket;
    new_depth  = cur_depth;
    draw       = 1'b0;
    advance    = 1'b0;
    err        = 1'b0;
    ret        = '0;
    case (command)
      CMD_LOCK, CMD_ACQUIRE_COUNT: begin
        if (take) begin
          if (overflow) begin
            err = 1'b1;
          end else begin
            new_depth = sum[DEPTH_BITS-1:0];
            if (depth_zero) begin
              draw       = 1'b1;
              new_ticket = next_ticket + TICKET_W'(1);
            end
          end
        end
      end
      CMD_UNLOCK: begin
        if (depth_zero) begin
          err = 1'b1;
        end else begin
          new_depth = cur_depth - DEPTH_BITS'(1);
          advance   = (cur_depth == DEPTH_BITS'(1));
        end
      end
      CMD_RELEASE_ALL: begin
        ret       = depth_wide[RET_W-1:0];
        new_depth = '0;
        advance   = 1'b1;
      end
      CMD_RELEASE_BUT_ONE: begin
        ret       = depth_less[RET_W-1:0];
        new_depth = DEPTH_BITS'(1);
      end
      default: begin
        // held query and unused codes: report only
      end
    endcase
  end

  assign status.write   = in_range;
  assign status.draw    = in_range && draw;
  assign status.advance = in_range && advance;
  assign status.err     = !in_range || err;

  assign next_ticket_next = status.draw ? next_ticket + TICKET_W'(1) : next_ticket;
  assign now_serving_next = status.advance ? now_serving + TICKET_W'(1) : now_serving;

  assign owned_ticket   = in_range ? new_ticket : '0;
  assign granted        = in_range && (new_ticket == now_serving_next) &&
                          (new_depth != '0);
  assign returned_depth = in_range ? $signed(ret) : '0;

endmodule

FILE: rtl/recursive_ticket_lock.sv
// Recursive ticket lock: one result item for every request item.
// Flow: the table entry is read as the request is accepted, then the command
// logic feeds the result register when the table stage advances.
// Throughput: one item per cycle while the result channel is not stalled; the table read is registered.
// Reset: synchronous; sets the ticket dispenser to 0 and now-serving to 1 and
// clears all table fill bits, so every CPU reads ticket 0 and depth 0 at once - no clearing pass.
module recursive_ticket_lock import rtlock_pkg::*; #(
  parameter int NUM_CPUS   = 64,
  parameter int DEPTH_BITS = 16
) (
  input logic         clk,
  input logic         rst,
  rtlock_req_if.sink  req,
  rtlock_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(NUM_CPUS);

  // Table stage: request held here while its table entry is read.
  logic               s1_valid;
  logic [CMD_W-1:0]   s1_command;
  logic [CNT_W-1:0]   s1_lock_count;
  logic               s1_in_range;
  logic [IDX_W-1:0]   s1_idx;
  logic               s1_adv;
  logic               req_fire;

  // Lock-wide counters.
  logic [TICKET_W-1:0] next_ticket;
  logic [TICKET_W-1:0] now_serving;

  // Table read data and command logic results.
  logic [TICKET_W-1:0]     cur_ticket;
  logic [DEPTH_BITS-1:0]   cur_depth;
  logic [TICKET_W-1:0]     new_ticket;
  logic [DEPTH_BITS-1:0]   new_depth;
  logic [TICKET_W-1:0]     next_ticket_next;
  logic [TICKET_W-1:0]     now_serving_next;
  status_t                 status;
  logic [TICKET_W-1:0]     res_ticket;
  logic                    res_granted;
  logic signed [RET_W-1:0] res_depth;

  // Advance the table stage whenever the result register is free or drains.
  assign s1_adv    = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign req_fire  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload of the table stage; no reset needed.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_command    <= req.command;
      s1_lock_count <= req.lock_count;
      s1_in_range   <= (32'(req.cpu_id) < 32'(NUM_CPUS));
      s1_idx        <= IDX_W'(req.cpu_id);
    end
  end

  // Per-CPU store; a write on the read edge of the same CPU is bypassed.
  rtlock_table #(
    .NUM_CPUS   (NUM_CPUS),
    .DEPTH_BITS (DEPTH_BITS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (req_fire),
    .rd_idx    (IDX_W'(req.cpu_id)),
    .wr_en     (s1_adv && status.write),
    .wr_idx    (s1_idx),
    .wr_ticket (new_ticket),
    .wr_depth  (new_depth),
    .rd_ticket (cur_ticket),
    .rd_depth  (cur_depth)
  );

  rtlock_update #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_update (
    .command          (s1_command),
    .lock_count       (s1_lock_count),
    .in_range         (s1_in_range),
    .cur_ticket       (cur_ticket),
    .cur_depth        (cur_depth),
    .next_ticket      (next_ticket),
    .now_serving      (now_serving),
    .new_ticket       (new_ticket),
    .new_depth        (new_depth),
    .next_ticket_next (next_ticket_next),
    .now_serving_next (now_serving_next),
    .status           (status),
    .owned_ticket     (res_ticket),
    .granted          (res_granted),
    .returned_depth   (res_depth)
  );

  // Commit the counters only when the item leaves the table stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_ticket <= '0;
      now_serving <= SERVING_RESET;
    end else if (s1_adv) begin
      next_ticket <= next_ticket_next;
      now_serving <= now_serving_next;
    end
  end

  // Result register: hold the item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.owned_ticket   <= res_ticket;
      rsp.granted        <= res_granted;
      rsp.returned_depth <= res_depth;
      rsp.error          <= status.err;
    end
  end

`include "recursive_ticket_lock_defines.svh"

  `RTLOCK_ASSERT_NEXT(a_serving_hold, !(s1_adv && status.advance), $stable(now_serving), "now-serving moved without a release")
  `RTLOCK_ASSERT_NEXT(a_draw_step, s1_adv && status.draw, next_ticket == $past(next_ticket) + TICKET_W'(1), "ticket dispenser did not step by one")
  `RTLOCK_ASSERT_NOW(a_err_no_draw, status.err, !status.draw && !status.advance, "failed command changed a counter")

endmodule
